@@ src/ugg_pkg.sv @@
package ugg_pkg;

  localparam int PosW    = 16;
  localparam int AngW    = 16;
  localparam int DiffW   = 17;
  localparam int GainW   = 12;
  localparam int DtolW   = 10;
  localparam int AtolW   = 12;
  localparam int SpdW    = 18;
  localparam int TurnW   = 18;
  localparam int CfgW    = 12;
  localparam int CfgIdxW = 3;
  localparam int SqW     = 33;   // dx^2 + dy^2 stays below 2^33
  localparam int RootW   = 17;   // floor(sqrt(d2)) below 2^17
  localparam int WrapW   = 18;

  localparam logic signed [WrapW-1:0] PiQ13    = 18'sd25736;
  localparam logic signed [WrapW-1:0] TwoPiQ13 = 18'sd51472;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_AIM  = 2'd1,
    PH_MOVE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQUARE,
    ST_SUM,
    ST_RUN,
    ST_RESOLVE,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINEAR_GAIN = 3'd0,
    REG_MOVE_GAIN   = 3'd1,
    REG_AIM_GAIN    = 3'd2,
    REG_DIST_TOL    = 3'd3,
    REG_ANGLE_TOL   = 3'd4
  } cfg_reg_t;

  // start / busy handshake between the sequencer and an iterative unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  // atan(2^-i) in Q.16
  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:    r = 17'd51472;
      5'd1:    r = 17'd30386;
      5'd2:    r = 17'd16055;
      5'd3:    r = 17'd8150;
      5'd4:    r = 17'd4091;
      5'd5:    r = 17'd2047;
      5'd6:    r = 17'd1024;
      5'd7:    r = 17'd512;
      5'd8:    r = 17'd256;
      5'd9:    r = 17'd128;
      5'd10:   r = 17'd64;
      5'd11:   r = 17'd32;
      5'd12:   r = 17'd16;
      5'd13:   r = 17'd8;
      5'd14:   r = 17'd4;
      5'd15:   r = 17'd2;
      5'd16:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // one-step wrap into (-pi, pi]; inputs never exceed 3*pi in magnitude
  function automatic logic signed [WrapW-1:0] wrap_angle(input logic signed [WrapW-1:0] a);
    logic signed [WrapW-1:0] r;
    if (a > PiQ13) r = a - TwoPiQ13;
    else if (a <= -PiQ13) r = a + TwoPiQ13;
    else r = a;
    return r;
  endfunction

endpackage

@@ src/ugg_if.sv @@
interface ugg_in_if;
  import ugg_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   start_segment;
  logic signed [PosW-1:0] pose_x;
  logic signed [PosW-1:0] pose_y;
  logic signed [AngW-1:0] pose_heading;
  logic signed [PosW-1:0] target_x;
  logic signed [PosW-1:0] target_y;

  modport source (output valid, start_segment, pose_x, pose_y, pose_heading,
                  target_x, target_y, input ready);
  modport sink (input valid, start_segment, pose_x, pose_y, pose_heading,
                target_x, target_y, output ready);
endinterface

interface ugg_out_if;
  import ugg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [SpdW-1:0]         forward_speed;
  logic signed [TurnW-1:0] turn_rate;
  logic [1:0]              phase;
  logic                    segment_done;

  modport source (output valid, forward_speed, turn_rate, phase, segment_done,
                  input ready);
  modport sink (input valid, forward_speed, turn_rate, phase, segment_done,
                output ready);
endinterface

@@ src/ugg_cordic.sv @@
module ugg_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ugg_pkg::unit_req_t               req,
  input  logic signed [ugg_pkg::DiffW-1:0] dx,
  input  logic signed [ugg_pkg::DiffW-1:0] dy,
  output logic                             busy,
  output logic signed [ugg_pkg::AngW-1:0]  angle
);
  import ugg_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS);
  localparam logic signed [19:0] HalfPi = 20'sd102944;

  logic signed [31:0] x, y, xi, yi;
  logic signed [19:0] z;
  logic [CW-1:0]      cnt;
  logic               zero;
  logic signed [19:0] atan_s;
  logic signed [19:0] zr;

  assign xi = {{3{dx[DiffW-1]}}, dx, 12'b0};
  assign yi = {{3{dy[DiffW-1]}}, dy, 12'b0};
  assign atan_s = signed'({3'b0, atan_q16(5'(cnt))});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      zero <= (dx == '0) && (dy == '0);
      if (xi < 0) begin
        if (yi >= 0) begin
          x <= yi; y <= -xi; z <= HalfPi;
        end else begin
          x <= -yi; y <= xi; z <= -HalfPi;
        end
      end else begin
        x <= xi; y <= yi; z <= '0;
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + (y >>> cnt);
        y <= y - (x >>> cnt);
        z <= z + atan_s;
      end else begin
        x <= x - (y >>> cnt);
        y <= y + (x >>> cnt);
        z <= z - atan_s;
      end
      cnt <= cnt + 1'b1;
      if (cnt == CW'(CORDIC_STEPS - 1)) busy <= 1'b0;
    end
  end

  // round Q.16 to Q2.13
  assign zr = (z + 20'sd4) >>> 3;
  assign angle = zero ? '0 : AngW'(wrap_angle(WrapW'(zr)));

endmodule

@@ src/ugg_isqrt.sv @@
module ugg_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  ugg_pkg::unit_req_t         req,
  input  logic [ugg_pkg::SqW-1:0]    value,
  output logic                       busy,
  output logic [ugg_pkg::RootW-1:0]  root
);
  import ugg_pkg::*;

  // two bits of the radicand per cycle
  logic [SqW-1:0] rem;
  logic [SqW:0]   r;
  logic [SqW-1:0] bitv;
  logic [SqW:0]   trial;

  assign trial = r + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      rem  <= value;
      r    <= '0;
      bitv <= {1'b1, {(SqW-1){1'b0}}};
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= SqW'({1'b0, rem} - trial);
        r   <= (r >> 1) + {1'b0, bitv};
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv[0]) busy <= 1'b0;
    end
  end

  assign root = r[RootW-1:0];

endmodule

@@ src/unicycle_go_to_goal_controller_unit.sv @@
// Channel | dir | handshake     | payload
// in_ch   | in  | valid / ready | start_segment, pose_x, pose_y, pose_heading, target_x/y
// out_ch  | out | valid / ready | forward_speed, turn_rate, phase, segment_done
// cfg     | in  | cfg_we        | cfg_index (register number), cfg_data
//
// An item passes from accept to result through load, square, sum, the CORDIC
// beside the 17-step square root with a wait until both are done, then resolve,
// multiply and output. The input is ready only in idle, so no new item is
// taken before the current one has left the output step.
// A new item is taken as soon as the previous one has moved into the result
// register; a stalled output holds its item while the next one computes.
// Reset (rst, synchronous) returns to idle phase with goal and aim zeroed and
// the registers at their defaults.
module unicycle_go_to_goal_controller_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  ugg_in_if.sink                              in_ch,
  ugg_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [ugg_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [ugg_pkg::CfgW-1:0]            cfg_data
);
  import ugg_pkg::*;

  // configuration
  logic [GainW-1:0] lin_gain, move_gain, aim_gain;
  logic [DtolW-1:0] reach_tol;
  logic [AtolW-1:0] ang_tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_gain  <= 12'd640;
      move_gain <= 12'd768;
      aim_gain  <= 12'd1024;
      reach_tol <= 10'd10;
      ang_tol   <= 12'd1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LINEAR_GAIN: lin_gain  <= cfg_data;
        REG_MOVE_GAIN:   move_gain <= cfg_data;
        REG_AIM_GAIN:    aim_gain  <= cfg_data;
        REG_DIST_TOL:    reach_tol <= cfg_data[DtolW-1:0];
        REG_ANGLE_TOL:   ang_tol   <= cfg_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // sequencer state
  state_t state, state_next;

  // item registers
  logic                    start_r;
  logic signed [PosW-1:0]  px, py;
  logic signed [AngW-1:0]  hd_raw, hd_w;
  logic signed [PosW-1:0]  goal_x, goal_y;
  logic signed [AngW-1:0]  aim_angle;
  phase_t                  ctl_phase;
  logic signed [DiffW-1:0] dx, dy;
  logic [31:0]             dxsq, dysq;
  logic [SqW-1:0]          d2, d2_sum;
  logic signed [33:0]      dx_sq_full, dy_sq_full;

  // resolve results
  phase_t                  res_phase;
  logic signed [DiffW-1:0] err;
  logic [GainW-1:0]        tgain;
  logic                    spd_en, turn_en, done_r;
  logic signed [29:0]      tprod;
  logic [28:0]             sprod;

  // output register
  logic                    out_valid;
  logic [SpdW-1:0]         out_speed;
  logic signed [TurnW-1:0] out_turn;
  phase_t                  out_phase;
  logic                    out_done;

  // units
  unit_req_t               cor_req, sq_req;
  logic                    cor_busy, sq_busy;
  logic signed [AngW-1:0]  cor_angle;
  logic [RootW-1:0]        root_val;

  logic in_fire, out_free;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign d2_sum   = {1'b0, dxsq} + {1'b0, dysq};
  assign dx_sq_full = dx * dx;
  assign dy_sq_full = dy * dy;

  ugg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .req(cor_req), .dx, .dy, .busy(cor_busy), .angle(cor_angle)
  );

  ugg_isqrt u_isqrt (
    .clk, .rst, .req(sq_req), .value(d2_sum), .busy(sq_busy), .root(root_val)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_ch.valid) state_next = ST_LOAD;
      ST_LOAD:    state_next = ST_SQUARE;
      ST_SQUARE:  state_next = ST_SUM;
      ST_SUM:     state_next = ST_RUN;
      ST_RUN:     if (!cor_busy && !sq_busy) state_next = ST_RESOLVE;
      ST_RESOLVE: state_next = ST_MUL;
      ST_MUL:     state_next = ST_OUT;
      ST_OUT:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready  = 1'b0;
    cor_req.start = 1'b0;
    sq_req.start  = 1'b0;
    unique case (state)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_SUM: begin
        cor_req.start = 1'b1;
        sq_req.start  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // phase decision for this item
  phase_t                  cur_phase;
  logic signed [WrapW-1:0] aim_err, move_err, aim_mag;
  logic signed [AngW-1:0]  aim_src;

  always_comb begin
    cur_phase = start_r ? PH_AIM : ctl_phase;
    aim_src   = start_r ? cor_angle : aim_angle;
    aim_err   = wrap_angle(WrapW'(aim_src) - WrapW'(hd_w));
    move_err  = wrap_angle(WrapW'(cor_angle) - WrapW'(hd_w));
    aim_mag   = (aim_err < 0) ? -aim_err : aim_err;
  end

  // outcome of the resolve step
  phase_t                  res_phase_next;
  logic signed [DiffW-1:0] err_next;
  logic [GainW-1:0]        tgain_next;
  logic                    spd_en_next, turn_en_next, done_next;
  logic [2*DtolW-1:0]      tol_sq;

  assign tol_sq = reach_tol * reach_tol;

  always_comb begin
    res_phase_next = PH_IDLE;
    err_next       = DiffW'(aim_err);
    tgain_next     = aim_gain;
    spd_en_next    = 1'b0;
    turn_en_next   = 1'b0;
    done_next      = 1'b0;
    unique case (cur_phase)
      PH_AIM: begin
        if (aim_mag <= signed'(WrapW'(ang_tol))) begin
          res_phase_next = PH_MOVE;
        end else begin
          res_phase_next = PH_AIM;
          turn_en_next   = 1'b1;
        end
      end
      PH_MOVE: begin
        if (d2 <= SqW'(tol_sq)) begin
          done_next = 1'b1;
        end else begin
          res_phase_next = PH_MOVE;
          spd_en_next    = 1'b1;
          turn_en_next   = 1'b1;
          err_next       = DiffW'(move_err);
          tgain_next     = move_gain;
        end
      end
      default: ;
    endcase
  end

  // saturation of the gain products
  logic [20:0]        spd_sh;
  logic signed [21:0] turn_sh;
  logic [SpdW-1:0]    spd_sat;
  logic signed [TurnW-1:0] turn_sat;

  always_comb begin
    spd_sh  = sprod[28:8];
    turn_sh = 22'(tprod >>> 8);
    spd_sat = (spd_sh > 21'd262143) ? {SpdW{1'b1}} : spd_sh[SpdW-1:0];
    if (turn_sh > 22'sd131071) turn_sat = 18'sd131071;
    else if (turn_sh < -22'sd131072) turn_sat = -18'sd131072;
    else turn_sat = turn_sh[TurnW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_phase <= PH_IDLE;
      goal_x    <= '0;
      goal_y    <= '0;
      aim_angle <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      if (in_fire && in_ch.start_segment) begin
        goal_x <= in_ch.target_x;
        goal_y <= in_ch.target_y;
      end
      // res_phase is settled once the resolve step is past
      if (state == ST_MUL) begin
        if (start_r) aim_angle <= cor_angle;
        ctl_phase <= res_phase;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      start_r <= in_ch.start_segment;
      px      <= in_ch.pose_x;
      py      <= in_ch.pose_y;
      hd_raw  <= in_ch.pose_heading;
    end
    case (state)
      ST_LOAD: begin
        dx   <= {goal_x[PosW-1], goal_x} - {px[PosW-1], px};
        dy   <= {goal_y[PosW-1], goal_y} - {py[PosW-1], py};
        hd_w <= AngW'(wrap_angle({{2{hd_raw[AngW-1]}}, hd_raw}));
      end
      ST_SQUARE: begin
        dxsq <= dx_sq_full[31:0];
        dysq <= dy_sq_full[31:0];
      end
      ST_SUM: d2 <= d2_sum;
      ST_RESOLVE: begin
        res_phase <= res_phase_next;
        err       <= err_next;
        tgain     <= tgain_next;
        spd_en    <= spd_en_next;
        turn_en   <= turn_en_next;
        done_r    <= done_next;
      end
      ST_MUL: begin
        tprod <= signed'({1'b0, tgain}) * err;
        sprod <= lin_gain * root_val;
      end
      ST_OUT: begin
        if (out_free) begin
          out_speed <= spd_en ? spd_sat : '0;
          out_turn  <= turn_en ? turn_sat : '0;
          out_phase <= res_phase;
          out_done  <= done_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.forward_speed = out_speed;
  assign out_ch.turn_rate     = out_turn;
  assign out_ch.phase         = out_phase;
  assign out_ch.segment_done  = out_done;

  // a finished segment always carries a zero command and idle phase
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_speed == '0 && out_turn == '0 && out_phase == PH_IDLE)
    else $error("segment_done with nonzero command");

  // turning in place never drives forward
  a_aim_no_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_phase == PH_AIM |-> out_speed == '0)
    else $error("forward speed while aiming");

  // units are only busy while the sequencer waits on them
  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !cor_busy && !sq_busy)
    else $error("iterative unit busy while accepting");

  // a result is loaded only from the output step
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("result appeared outside output step");

endmodule

@@ sim/ugg_checker.sv @@
module ugg_checker
  import ugg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  ugg_in_if                  in_ch,
  ugg_out_if                 out_ch,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output int                 fails,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [SpdW-1:0]         speed;
    logic signed [TurnW-1:0] turn;
    phase_t                  ph;
    logic                    done;
  } cmd_t;

  cmd_t cmd_q[$];

  // shadow of the block's registers and segment state
  longint lin_gain, mv_gain, aim_gain, reach_tol, ang_tol;
  longint goal_x, goal_y, aim_ang;
  phase_t ctl_ph;

  function automatic longint wrap_pi(longint a);
    while (a > 25736) a -= 51472;
    while (a <= -25736) a += 51472;
    return a;
  endfunction

  function automatic longint atan_step(int i);
    case (i)
      0: return 51472;  1: return 30386;  2: return 16055;  3: return 8150;
      4: return 4091;   5: return 2047;   6: return 1024;   7: return 512;
      8: return 256;    9: return 128;   10: return 64;    11: return 32;
      12: return 16;   13: return 8;     14: return 4;     15: return 2;
      16: return 1;
      default: return 0;
    endcase
  endfunction

  // vectoring CORDIC, Q.16 accumulator rounded to Q2.13
  function automatic longint bearing_q13(longint dy, longint dx);
    longint x, y, z, t, xs, ys;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 4096;
    y = dy * 4096;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 102944;
      end else begin
        x = -y; y = t; z = -102944;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    return wrap_pi((z + 4) >>> 3);
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 36;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint turn_sat(longint g, longint e);
    longint v;
    v = (g * e) >>> 8;
    if (v < -131072) v = -131072;
    if (v > 131071) v = 131071;
    return v;
  endfunction

  task automatic predict_cmd(output cmd_t r);
    longint px, py, hd, dx, dy, err, d2, spd;
    px = longint'(in_ch.pose_x);
    py = longint'(in_ch.pose_y);
    hd = wrap_pi(longint'(in_ch.pose_heading));
    r.speed = '0;
    r.turn  = '0;
    r.done  = 1'b0;
    if (in_ch.start_segment) begin
      goal_x  = longint'(in_ch.target_x);
      goal_y  = longint'(in_ch.target_y);
      aim_ang = bearing_q13(goal_y - py, goal_x - px);
      ctl_ph  = PH_AIM;
    end
    dx = goal_x - px;
    dy = goal_y - py;
    case (ctl_ph)
      PH_AIM: begin
        err = wrap_pi(aim_ang - hd);
        if ((err < 0 ? -err : err) <= ang_tol) ctl_ph = PH_MOVE;
        else r.turn = TurnW'(turn_sat(aim_gain, err));
      end
      PH_MOVE: begin
        d2 = dx * dx + dy * dy;
        if (d2 <= reach_tol * reach_tol) begin
          ctl_ph = PH_IDLE;
          r.done = 1'b1;
        end else begin
          err = wrap_pi(bearing_q13(dy, dx) - hd);
          spd = (lin_gain * root_floor(d2)) >>> 8;
          if (spd > 262143) spd = 262143;
          r.speed = SpdW'(spd);
          r.turn  = TurnW'(turn_sat(mv_gain, err));
        end
      end
      default: ctl_ph = PH_IDLE;
    endcase
    r.ph = ctl_ph;
  endtask

  always @(posedge clk) begin
    cmd_t e;
    if (rst) begin
      lin_gain = 640; mv_gain = 768; aim_gain = 1024; reach_tol = 10; ang_tol = 1;
      goal_x = 0; goal_y = 0; aim_ang = 0; ctl_ph = PH_IDLE;
      cmd_q.delete();
      fails <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LINEAR_GAIN: lin_gain  = cfg_data;
          REG_MOVE_GAIN:   mv_gain   = cfg_data;
          REG_AIM_GAIN:    aim_gain  = cfg_data;
          REG_DIST_TOL:    reach_tol = cfg_data[DtolW-1:0];
          REG_ANGLE_TOL:   ang_tol   = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_cmd(e);
        cmd_q.push_back(e);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (cmd_q.size() == 0) begin
          $display("%0t: unexpected item, got speed %0d turn %0d phase %0d done %0d",
                   $time, out_ch.forward_speed, out_ch.turn_rate, out_ch.phase,
                   out_ch.segment_done);
          fails <= fails + 1;
        end else begin
          e = cmd_q.pop_front();
          if (out_ch.forward_speed !== e.speed || out_ch.turn_rate !== e.turn ||
              out_ch.phase !== e.ph || out_ch.segment_done !== e.done) begin
            $display("%0t: mismatch exp speed %0d turn %0d phase %0d done %0d",
                     $time, e.speed, e.turn, e.ph, e.done);
            $display("%0t:          got speed %0d turn %0d phase %0d done %0d",
                     $time, out_ch.forward_speed, out_ch.turn_rate, out_ch.phase,
                     out_ch.segment_done);
            fails <= fails + 1;
          end
        end
      end
      pending <= cmd_q.size();
    end
  end

endmodule

@@ sim/tb.sv @@
module tb;
  import ugg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;
  int                 fails, pending;

  int items_sent = 0;   // accepted input items
  int starts_sent = 0;  // start items among them
  bit calm = 1'b0;      // no idling on either side while set
  bit held = 1'b0;      // long output hold-off already done

  ugg_in_if  in_ch();
  ugg_out_if out_ch();

  always #10 clk = ~clk;

  unicycle_go_to_goal_controller_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ugg_checker u_chk (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fails    (fails),
    .pending  (pending)
  );

  // watchdog: generous against the slowest correct run
  initial begin
    #10ms;
    $display("tb failed");
    $finish;
  end

  // output side: random back-pressure, one long hold-off mid-run so the
  // block fills up and has to stall its input
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && items_sent >= 400) begin
        held = 1'b1;
        out_ch.ready = 1'b0;
        repeat (300) @(negedge clk);
      end
      out_ch.ready = calm ? 1'b1 : ($urandom_range(99) >= 13);
    end
  end

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // one item: drive at the falling edge, hold until accepted, maybe idle
  task automatic send_pose(bit st, longint px, longint py, longint hd,
                           longint tx, longint ty);
    @(negedge clk);
    in_ch.valid         = 1'b1;
    in_ch.start_segment = st;
    in_ch.pose_x        = clamp16(px);
    in_ch.pose_y        = clamp16(py);
    in_ch.pose_heading  = clamp16(hd);
    in_ch.target_x      = clamp16(tx);
    in_ch.target_y      = clamp16(ty);
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (st) starts_sent++;
    if (!calm && $urandom_range(99) < 13) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // registers change only with nothing in flight
  task automatic drain;
    @(negedge clk);
    in_ch.valid = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(int lg, int mg, int ag, int dt, int at);
    drain();
    write_reg(REG_LINEAR_GAIN, CfgW'(lg));
    write_reg(REG_MOVE_GAIN, CfgW'(mg));
    write_reg(REG_AIM_GAIN, CfgW'(ag));
    write_reg(REG_DIST_TOL, CfgW'(dt));
    write_reg(REG_ANGLE_TOL, CfgW'(at));
  endtask

  function automatic longint rnd16();
    return longint'($signed(16'($urandom)));
  endfunction

  // heading near the true bearing, now and then shifted by a full turn
  function automatic longint near_heading(longint px, longint py, longint tx, longint ty,
                                          longint off);
    longint h;
    h = $rtoi($atan2(real'(ty - py), real'(tx - px)) * 8192.0) + off;
    if ($urandom_range(3) == 0) begin
      if (h + 51472 <= 32767) h += 51472;
      else if (h - 51472 >= -32768) h -= 51472;
    end
    return h;
  endfunction

  // segment: start with target (random, tx), a few aiming poses closing
  // in on the tx/ty bearing, then poses walking to tx/ty, last near it
  task automatic run_segment;
    longint px, py, tx, ty, sx, sy, err;
    int k, m, span;
    span = ($urandom_range(3) == 0) ? 32767 : 3000;
    px = longint'($urandom_range(2 * span)) - span;
    py = longint'($urandom_range(2 * span)) - span;
    tx = longint'($urandom_range(2 * span)) - span;
    ty = longint'($urandom_range(2 * span)) - span;
    sx = px; sy = py;
    err = longint'($urandom_range(40000)) - 20000;
    send_pose(1'b1, px, py, near_heading(px, py, tx, ty, err), rnd16(), rnd16() * 0 + tx);
    k = $urandom_range(3);
    for (int i = 0; i < k; i++) begin
      err = err / 3;
      send_pose(1'b0, px, py, near_heading(sx, sy, tx, ty, err), rnd16(), rnd16());
    end
    send_pose(1'b0, px, py,
              near_heading(sx, sy, tx, ty, longint'($urandom_range(6)) - 3),
              rnd16(), rnd16());
    m = $urandom_range(1, 8);
    for (int i = 1; i <= m; i++) begin
      px = sx + (tx - sx) * i / (m + 1);
      py = sy + (ty - sy) * i / (m + 1);
      send_pose(1'b0, px, py,
                near_heading(px, py, tx, ty, longint'($urandom_range(400)) - 200),
                rnd16(), rnd16());
    end
    send_pose(1'b0, tx + longint'($urandom_range(4)) - 2, ty, rnd16(), rnd16(), rnd16());
  endtask

  task automatic run_random(int upto);
    while (items_sent < upto) begin
      if ($urandom_range(4) == 0)
        send_pose($urandom_range(1), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
      else
        run_segment();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.start_segment = 1'b0;
    in_ch.pose_x = '0;
    in_ch.pose_y = '0;
    in_ch.pose_heading = '0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset register values
    send_pose(1'b0, 32767, -32768, 32767, -32768, 32767);     // idle output
    send_pose(1'b1, 500, 500, 0, 500, 500);                   // zero offset
    send_pose(1'b0, 500, 500, 0, 0, 0);                       // goal reached at once
    send_pose(1'b1, -32768, -32768, -32768, 32767, 32767);    // far corner, aim
    send_pose(1'b0, -32768, -32768, 32767, 0, 0);
    send_pose(1'b1, 32767, 32767, 32767, -32768, -32768);     // restart while aiming
    send_pose(1'b1, 0, 0, 0, 8000, 0);                        // along +x, aim met
    send_pose(1'b0, 2000, 0, 0, 0, 0);                        // moving
    send_pose(1'b0, 4000, 100, -32768, 0, 0);                 // heading wraps
    send_pose(1'b1, 0, 0, 25736, -8000, 0);                   // bearing at pi, restart in move
    send_pose(1'b0, -3000, 0, -25736, 0, 0);
    send_pose(1'b0, -7995, 5, 0, 0, 0);                       // inside tolerance
    send_pose(1'b0, -7995, 5, 0, 0, 0);                       // idle again
    send_pose(1'b1, 0, 0, -12868, 0, -30000);                 // straight down
    send_pose(1'b0, 0, 0, -12868, 0, 0);
    send_pose(1'b0, 0, -32768, 12868, 0, 0);                  // overshoot, far
    send_pose(1'b1, 32767, -32768, -1, -32768, 32767);
    send_pose(1'b0, 32767, -32768, 1, 0, 0);

    set_regs($urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(1, 4095),
             $urandom_range(50, 400), $urandom_range(20, 200));
    run_random(150);
    calm = 1'b1;
    run_random(300);
    calm = 1'b0;
    run_random(420);

    // extremes: everything at full scale
    set_regs(4095, 4095, 4095, 1023, 4095);
    run_random(500);

    // extremes: all zero, exact tolerances
    set_regs(0, 0, 0, 0, 0);
    run_random(570);

    // bits above a register's width and unknown indexes are dropped
    set_regs($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
             12'hC00 | $urandom_range(1023), $urandom_range(100));
    write_reg(CfgIdxW'(REG_ANGLE_TOL + 1), 12'hFFF);
    write_reg(CfgIdxW'(REG_ANGLE_TOL + 3), 12'h000);
    run_random(750);

    drain();
    $display("covered %0d pose items, %0d segment starts, five register settings",
             items_sent, starts_sent);
    $display("including all-max and all-zero gains and a long output stall");
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ugg_pkg.sv
src/ugg_if.sv
src/ugg_cordic.sv
src/ugg_isqrt.sv
src/unicycle_go_to_goal_controller_unit.sv
sim/ugg_checker.sv
sim/tb.sv
